>>> src/sts_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the sorted table binary search block.
package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BYTES_DEF   = 20;
    localparam int KEY_BITS_MAX    = 160;
    localparam int COUNT_W         = 7;
    localparam int SLOT_W          = 6;
    localparam int BYTE_W          = 8;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } sts_cmp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } sts_state_t;

endpackage

>>> src/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Sorted table binary search: a load word writes one record into the table; a search
// word runs a binary search over the first entry_count records (saturated at
// TABLE_DEPTH) and returns one word with found, index, sex and age. Each probe is one
// registered table read followed by one key compare. A finished search waits to hand
// over its result while a stalled earlier result word has not yet left. The input
// stalls while a search is in progress; the result word sits in an output register so
// the next word can be taken while it waits.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = sts_pkg::KEY_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sts_pkg::COUNT_W-1:0] entry_count,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [sts_pkg::SLOT_W-1:0]  slot,
    input  logic [63:0]                 key_bytes_0_7,
    input  logic [63:0]                 key_bytes_8_15,
    input  logic [31:0]                 key_bytes_16_19,
    input  logic [sts_pkg::BYTE_W-1:0]  sex_code,
    input  logic [sts_pkg::BYTE_W-1:0]  age_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [sts_pkg::SLOT_W-1:0]  match_index,
    output logic [sts_pkg::BYTE_W-1:0]  match_sex,
    output logic [sts_pkg::BYTE_W-1:0]  match_age
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = KEY_BYTES * sts_pkg::BYTE_W;

    logic [sts_pkg::COUNT_W-1:0]      entry_count_reg;
    logic [sts_pkg::KEY_BITS_MAX-1:0] full_key;
    logic [KW-1:0]                    in_key;
    logic [KW-1:0]                    probe_key;
    logic [KW-1:0]                    rd_key;
    logic [sts_pkg::BYTE_W-1:0]       rd_sex;
    logic [sts_pkg::BYTE_W-1:0]       rd_age;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic                             wr_en;
    sts_pkg::sts_cmp_t                cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= entry_count;
        end
    end

    assign cfg_ready = 1'b1;
    assign full_key  = {key_bytes_0_7, key_bytes_8_15, key_bytes_16_19};
    assign in_key    = full_key[sts_pkg::KEY_BITS_MAX-1 -: KW];

    // drop loads whose slot falls outside the table
    assign wr_en = in_valid && !in_stall && func == sts_pkg::FUNC_LOAD
                   && int'(slot) < TABLE_DEPTH;

    sts_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .KW    (KW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(slot)),
        .wr_key  (in_key),
        .wr_sex  (sex_code),
        .wr_age  (age_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_sex  (rd_sex),
        .rd_age  (rd_age)
    );

    sts_key_cmp #(
        .KW (KW)
    ) u_cmp (
        .probe_key (probe_key),
        .table_key (rd_key),
        .result    (cmp)
    );

    sts_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .KW    (KW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (in_key),
        .count       (entry_count_reg),
        .probe_key   (probe_key),
        .cmp         (cmp),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_sex      (rd_sex),
        .rd_age      (rd_age),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .match_sex   (match_sex),
        .match_age   (match_age)
    );

endmodule

>>> src/sts_table_mem.sv
`timescale 1ns / 1ps
// Record table memory: one write port, one registered read port.
module sts_table_mem #(
    parameter int DEPTH = sts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int KW    = sts_pkg::KEY_BYTES_DEF * sts_pkg::BYTE_W
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [KW-1:0]               wr_key,
    input  logic [sts_pkg::BYTE_W-1:0]  wr_sex,
    input  logic [sts_pkg::BYTE_W-1:0]  wr_age,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [KW-1:0]               rd_key,
    output logic [sts_pkg::BYTE_W-1:0]  rd_sex,
    output logic [sts_pkg::BYTE_W-1:0]  rd_age
);

    localparam int RW = KW + 2 * sts_pkg::BYTE_W;

    logic [RW-1:0] mem [DEPTH];
    logic [RW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_sex, wr_age};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key = rd_data_reg[RW-1 -: KW];
    assign rd_sex = rd_data_reg[2*sts_pkg::BYTE_W-1 -: sts_pkg::BYTE_W];
    assign rd_age = rd_data_reg[sts_pkg::BYTE_W-1:0];

endmodule

>>> src/sts_key_cmp.sv
`timescale 1ns / 1ps
// Shared key comparator: unsigned magnitude compare, first byte most significant.
module sts_key_cmp #(
    parameter int KW = sts_pkg::KEY_BYTES_DEF * sts_pkg::BYTE_W
) (
    input  logic [KW-1:0]     probe_key,
    input  logic [KW-1:0]     table_key,
    output sts_pkg::sts_cmp_t result
);

    always_comb
    begin
        if (probe_key == table_key)
        begin
            result = sts_pkg::CMP_EQ;
        end
        else if (probe_key < table_key)
        begin
            result = sts_pkg::CMP_LT;
        end
        else
        begin
            result = sts_pkg::CMP_GT;
        end
    end

endmodule

>>> src/sts_ctrl.sv
`timescale 1ns / 1ps
// Search sequencer: probe bounds, table read control and the output word register.
module sts_ctrl #(
    parameter int DEPTH = sts_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int KW    = sts_pkg::KEY_BYTES_DEF * sts_pkg::BYTE_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [KW-1:0]               key,
    input  logic [sts_pkg::COUNT_W-1:0] count,
    output logic [KW-1:0]               probe_key,
    input  sts_pkg::sts_cmp_t           cmp,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [sts_pkg::BYTE_W-1:0]  rd_sex,
    input  logic [sts_pkg::BYTE_W-1:0]  rd_age,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [sts_pkg::SLOT_W-1:0]  match_index,
    output logic [sts_pkg::BYTE_W-1:0]  match_sex,
    output logic [sts_pkg::BYTE_W-1:0]  match_age
);

    localparam int NW = $clog2(DEPTH + 1);

    sts_pkg::sts_state_t state_reg, state_next;

    logic [NW-1:0]              lo_reg, lo_next;
    logic [NW-1:0]              hi_reg, hi_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic [KW-1:0]              key_reg, key_next;
    logic                       res_found_reg, res_found_next;
    logic [sts_pkg::SLOT_W-1:0] res_index_reg, res_index_next;
    logic [sts_pkg::BYTE_W-1:0] res_sex_reg, res_sex_next;
    logic [sts_pkg::BYTE_W-1:0] res_age_reg, res_age_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_found_reg, out_found_next;
    logic [sts_pkg::SLOT_W-1:0] out_index_reg, out_index_next;
    logic [sts_pkg::BYTE_W-1:0] out_sex_reg, out_sex_next;
    logic [sts_pkg::BYTE_W-1:0] out_age_reg, out_age_next;

    logic [NW-1:0]              count_sat;
    logic [NW:0]                bound_sum;
    logic [AW-1:0]              mid_calc;
    logic [AW+5:0]              mid_ext;

    assign count_sat = (int'(count) >= DEPTH) ? NW'(DEPTH) : NW'(count);
    assign bound_sum = (NW+1)'(lo_reg) + (NW+1)'(hi_reg) - (NW+1)'(1);
    assign mid_calc  = AW'(bound_sum >> 1);
    assign mid_ext   = (AW+6)'(mid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        res_sex_reg   <= res_sex_next;
        res_age_reg   <= res_age_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_sex_reg   <= out_sex_next;
        out_age_reg   <= out_age_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        res_sex_next   = res_sex_reg;
        res_age_next   = res_age_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_sex_next   = out_sex_reg;
        out_age_next   = out_age_reg;
        rd_en          = 1'b0;

        case (state_reg)
            sts_pkg::ST_IDLE:
            begin
                if (in_valid && func == sts_pkg::FUNC_SEARCH)
                begin
                    key_next       = key;
                    lo_next        = '0;
                    hi_next        = count_sat;
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    res_sex_next   = '0;
                    res_age_next   = '0;
                    state_next     = sts_pkg::ST_ADDR;
                end
            end
            sts_pkg::ST_ADDR:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid_calc;
                    state_next = sts_pkg::ST_CMP;
                end
                else
                begin
                    state_next = sts_pkg::ST_DONE;
                end
            end
            sts_pkg::ST_CMP:
            begin
                case (cmp)
                    sts_pkg::CMP_EQ:
                    begin
                        res_found_next = 1'b1;
                        res_index_next = mid_ext[sts_pkg::SLOT_W-1:0];
                        res_sex_next   = rd_sex;
                        res_age_next   = rd_age;
                        state_next     = sts_pkg::ST_DONE;
                    end
                    sts_pkg::CMP_LT:
                    begin
                        hi_next    = NW'(mid_reg);
                        state_next = sts_pkg::ST_ADDR;
                    end
                    sts_pkg::CMP_GT:
                    begin
                        lo_next    = NW'(mid_reg) + NW'(1);
                        state_next = sts_pkg::ST_ADDR;
                    end
                    default:
                    begin
                        state_next = sts_pkg::ST_DONE;
                    end
                endcase
            end
            sts_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_index_next = res_index_reg;
                    out_sex_next   = res_sex_reg;
                    out_age_next   = res_age_reg;
                    state_next     = sts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != sts_pkg::ST_IDLE);
    assign rd_addr     = mid_calc;
    assign probe_key   = key_reg;
    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign match_index = out_index_reg;
    assign match_sex   = out_sex_reg;
    assign match_age   = out_age_reg;

`ifndef NO_ASSERTIONS
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sts_pkg::ST_CMP |-> $past(state_reg) == sts_pkg::ST_ADDR)
        else $error("compare step without a preceding table read");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sts_pkg::ST_ADDR || state_reg == sts_pkg::ST_CMP) |->
        (lo_reg <= hi_reg && int'(hi_reg) <= DEPTH))
        else $error("search bounds out of order");

    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sts_pkg::ST_CMP |->
        (NW'(mid_reg) >= lo_reg && NW'(mid_reg) < hi_reg))
        else $error("probe index outside search window");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |->
        (out_index_reg == '0 && out_sex_reg == '0 && out_age_reg == '0))
        else $error("not-found word carries nonzero fields");
`endif

endmodule
